### rtl/core/lzo1x_stream_decompressor_core_macros.svh
// assertion macros for the lzo1x decompressor core
`ifndef LZO1X_STREAM_DECOMPRESSOR_CORE_MACROS_SVH
`define LZO1X_STREAM_DECOMPRESSOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LZD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzd assertion failed");
`define LZD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzd assertion failed");
`else
`define LZD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LZD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/lzd_pkg.sv
package lzd_pkg;

  localparam int unsigned WindowBytesDefault = 65536;
  localparam int unsigned ChunkBytesDefault  = 16;
  localparam int unsigned MaxOut             = 16;

  typedef enum logic [3:0] {
    PH_FIRST, PH_OUTER, PH_AFTER_LIT, PH_AFTER_SHORT, PH_LIT_EXT, PH_LIT, PH_TRAIL,
    PH_M1_SHORT, PH_M1_LONG, PH_M2_OFF, PH_LEN_EXT, PH_DIST_LO, PH_DIST_HI,
    PH_COPY, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_PENDING = 2'd1, ST_END = 2'd2, ST_ERROR = 2'd3
  } status_t;

  typedef enum logic {OP_PUSH = 1'b0, OP_PULL = 1'b1} opcode_t;

  // sequencer state of the control unit
  typedef enum logic [2:0] {
    SQ_IDLE, SQ_PARSE, SQ_RD, SQ_WAIT, SQ_WR, SQ_EMPTY
  } seq_t;

  // control to history memory
  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [15:0] rd_addr;
  } hist_req_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/core/lzd_history.sv
module lzd_history
  import lzd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytesDefault
) (
  input  logic      clk,
  input  hist_req_t req,
  output logic [7:0] rd_data
);
  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  logic [7:0] mem [WINDOW_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end
endmodule

### rtl/core/lzd_ctrl.sv
`include "lzo1x_stream_decompressor_core_macros.svh"
module lzd_ctrl
  import lzd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytesDefault,
  parameter int unsigned CHUNK_BYTES  = ChunkBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_bv,
  output logic        out_last,
  output logic [1:0]  out_status,
  output hist_req_t   hreq,
  input  logic [7:0]  hrd
);
  localparam int unsigned LimRaw = (CHUNK_BYTES > MaxOut) ? MaxOut : CHUNK_BYTES;
  localparam int unsigned Limit  = (LimRaw < 1) ? 1 : LimRaw;
  localparam int unsigned CW     = $clog2(MaxOut + 1);
  localparam logic [CW-1:0] LimitC = CW'(Limit);
  localparam logic [16:0] WinC = 17'(WINDOW_BYTES);

  seq_t seq, seq_next;
  phase_t phase;
  logic [31:0] out_count, pend;
  logic [7:0]  tok, low_off, b;
  logic [15:0] match_dist, wpos;
  logic [1:0]  trail;
  logic        op;
  logic [CW-1:0] nout;

  // output register
  logic        ov;
  logic [7:0]  ob;
  logic        obv, olast;
  logic        oload;

  // parse decode (combinational, one byte)
  phase_t pn;
  logic [31:0] pend_n;
  logic [7:0]  tok_n, low_n;
  logic [1:0]  trail_n;
  logic [15:0] match_dist_n;
  logic        emit_lit, start;
  logic [31:0] sdist, slen;
  logic [7:0]  strail;
  logic [15:0] off16;
  logic [31:0] base;
  logic        serr;
  logic [16:0] wp_n;

  always_comb begin
    pn = phase; pend_n = pend; tok_n = tok; low_n = low_off; trail_n = trail;
    match_dist_n = match_dist;
    emit_lit = 1'b0; start = 1'b0;
    sdist = '0; slen = '0; strail = '0;
    off16 = 16'({b, low_off} >> 2);
    base = {17'd0, tok[3], 14'd0};
    unique case (phase)
      PH_FIRST, PH_OUTER, PH_AFTER_LIT, PH_AFTER_SHORT: begin
        if (phase == PH_FIRST && b > 8'd17) begin
          if (b - 8'd17 < 8'd4) begin
            trail_n = 2'(b - 8'd17); pn = PH_TRAIL;
          end else begin
            pend_n = 32'(b - 8'd17); pn = PH_LIT;
          end
        end else if (b >= 8'd16) begin
          tok_n = b;
          if (b >= 8'd64) pn = PH_M2_OFF;
          else if (b >= 8'd32) begin
            if (b[4:0] == 5'd0) begin pend_n = 32'd31; pn = PH_LEN_EXT; end
            else begin pend_n = 32'(b[4:0]); pn = PH_DIST_LO; end
          end else begin
            if (b[2:0] == 3'd0) begin pend_n = 32'd7; pn = PH_LEN_EXT; end
            else begin pend_n = 32'(b[2:0]); pn = PH_DIST_LO; end
          end
        end else if (phase == PH_AFTER_LIT) begin
          tok_n = b; pn = PH_M1_LONG;
        end else if (phase == PH_AFTER_SHORT) begin
          tok_n = b; pn = PH_M1_SHORT;
        end else if (b == 8'd0) begin
          pend_n = '0; pn = PH_LIT_EXT;
        end else begin
          pend_n = 32'(b) + 32'd3; pn = PH_LIT;
        end
      end
      PH_LIT_EXT, PH_LEN_EXT: begin
        if (b == 8'd0) pend_n = sat_add(pend, 32'd255);
        else begin
          pend_n = sat_add(pend, (phase == PH_LIT_EXT) ? 32'(b) + 32'd18 : 32'(b));
          pn = (phase == PH_LIT_EXT) ? PH_LIT : PH_DIST_LO;
        end
      end
      PH_LIT: begin
        emit_lit = 1'b1;
        if (pend != '0) pend_n = pend - 32'd1;
        if (pend <= 32'd1) pn = PH_AFTER_LIT;
      end
      PH_TRAIL: begin
        emit_lit = 1'b1;
        if (trail != '0) trail_n = trail - 2'd1;
        if (trail <= 2'd1) pn = PH_AFTER_SHORT;
      end
      PH_M1_SHORT: begin
        start = 1'b1; sdist = 32'd1 + 32'(tok >> 2) + {22'd0, b, 2'd0};
        slen = 32'd2; strail = tok;
      end
      PH_M1_LONG: begin
        start = 1'b1; sdist = 32'h801 + 32'(tok >> 2) + {22'd0, b, 2'd0};
        slen = 32'd3; strail = tok;
      end
      PH_M2_OFF: begin
        start = 1'b1; sdist = 32'd1 + 32'(tok[4:2]) + {21'd0, b, 3'd0};
        slen = 32'(tok[7:5]) + 32'd1; strail = tok;
      end
      PH_DIST_LO: begin
        low_n = b; pn = PH_DIST_HI;
      end
      PH_DIST_HI: begin
        slen = sat_add(pend, 32'd2); strail = low_off;
        if (tok >= 8'd32) begin
          start = 1'b1; sdist = 32'd1 + 32'(off16);
        end else if (base + 32'(off16) == '0) begin
          pn = PH_DONE; pend_n = '0;
        end else begin
          start = 1'b1; sdist = base + 32'(off16) + 32'h4000;
        end
      end
      default: ;
    endcase
    serr = (sdist == '0) || (sdist > out_count) || (sdist > 32'(WINDOW_BYTES));
    // a match either starts copying or lands in the error state
    if (start) begin
      trail_n = strail[1:0];
      if (serr) begin
        pn = PH_ERROR; pend_n = '0;
      end else begin
        pn = PH_COPY; pend_n = slen; match_dist_n = sdist[15:0];
      end
    end
  end

  logic [16:0] rd_idx;
  assign rd_idx = ({1'b0, wpos} >= {1'b0, match_dist})
                ? {1'b0, wpos} - {1'b0, match_dist}
                : {1'b0, wpos} + WinC - {1'b0, match_dist};
  assign wp_n = ({1'b0, wpos} + 17'd1 == WinC) ? 17'd0 : {1'b0, wpos} + 17'd1;

  logic drain_more;
  assign drain_more = (pend != '0) && (nout < LimitC);

  // the rest of the match fits in this chunk
  logic chunk_fin;
  assign chunk_fin = (pend <= 32'(Limit) - 32'(nout));

  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_IDLE:  if (in_valid) seq_next = SQ_PARSE;
      SQ_PARSE: begin
        if (!ov || out_ready) begin
          if (op == OP_PULL) seq_next = (phase == PH_COPY) ? SQ_RD : SQ_EMPTY;
          else if (phase == PH_COPY || phase == PH_DONE || phase == PH_ERROR) seq_next = SQ_EMPTY;
          else if (emit_lit) seq_next = SQ_IDLE;
          else if (start && !serr) seq_next = SQ_RD;
          else seq_next = SQ_EMPTY;
        end
      end
      SQ_RD:    seq_next = SQ_WAIT;
      SQ_WAIT:  if (!ov || out_ready) seq_next = SQ_WR;
      SQ_WR:    seq_next = drain_more ? SQ_RD : (nout == '0 ? SQ_EMPTY : SQ_IDLE);
      SQ_EMPTY: if (!ov || out_ready) seq_next = SQ_IDLE;
      default:  seq_next = SQ_IDLE;
    endcase
  end

  // output register loads a new result
  assign oload = (!ov || out_ready) &&
                 ((seq == SQ_PARSE && op == OP_PUSH && emit_lit && phase != PH_COPY &&
                   phase != PH_DONE && phase != PH_ERROR) ||
                  seq == SQ_WAIT || seq == SQ_EMPTY);

  // in SQ_WAIT the memory byte is written back and presented
  always_comb begin
    hreq = '0;
    in_ready = (seq == SQ_IDLE);
    if (seq == SQ_RD) begin
      hreq.rd_en = 1'b1; hreq.rd_addr = rd_idx[15:0];
    end
    if (seq == SQ_PARSE && (!ov || out_ready) && op == OP_PUSH && emit_lit &&
        phase != PH_COPY) begin
      hreq.wr_en = 1'b1; hreq.wr_addr = wpos; hreq.wr_data = b;
    end
    if (seq == SQ_WAIT && (!ov || out_ready)) begin
      hreq.wr_en = 1'b1; hreq.wr_addr = wpos; hreq.wr_data = hrd;
    end
  end

  function automatic logic [1:0] stat_of(input phase_t p);
    return (p == PH_COPY) ? ST_PENDING : (p == PH_DONE) ? ST_END :
           (p == PH_ERROR) ? ST_ERROR : ST_OK;
  endfunction

  logic [31:0] pend_after;
  assign pend_after = pend - 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE; phase <= PH_FIRST; out_count <= '0; pend <= '0; tok <= '0;
      low_off <= '0; match_dist <= '0; trail <= '0; wpos <= '0; ov <= 1'b0; nout <= '0;
    end else begin
      seq <= seq_next;
      if (oload) ov <= 1'b1;
      else if (out_ready) ov <= 1'b0;
      unique case (seq)
        SQ_IDLE: if (in_valid) begin
          op <= in_op; b <= in_byte; nout <= '0;
        end
        SQ_PARSE: if (!ov || out_ready) begin
          if (op == OP_PUSH && phase != PH_COPY && phase != PH_DONE && phase != PH_ERROR) begin
            phase <= pn; pend <= pend_n; tok <= tok_n; low_off <= low_n; trail <= trail_n;
            match_dist <= match_dist_n;
            if (emit_lit) begin
              ob <= b; obv <= 1'b1; olast <= 1'b1;
              out_status <= stat_of(pn);
              wpos <= wp_n[15:0]; out_count <= sat_add(out_count, 32'd1);
            end
          end
        end
        SQ_WAIT: if (!ov || out_ready) begin
          ob <= hrd; obv <= 1'b1;
          wpos <= wp_n[15:0]; out_count <= sat_add(out_count, 32'd1);
          pend <= pend_after; nout <= nout + CW'(1);
          olast <= (pend_after == '0) || (nout + CW'(1) >= LimitC);
          out_status <= chunk_fin ? ST_OK : ST_PENDING;
          if (pend_after == '0) phase <= (trail == '0) ? PH_OUTER : PH_TRAIL;
        end
        SQ_EMPTY: if (!ov || out_ready) begin
          ob <= '0; obv <= 1'b0; olast <= 1'b1; out_status <= stat_of(phase);
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov;
  assign out_byte  = ob;
  assign out_bv    = obv;
  assign out_last  = olast;

  `LZD_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, seq == SQ_IDLE)
  `LZD_ASSERT_NEXT(a_err_sticky, clk, rst, phase == PH_ERROR, phase == PH_ERROR)
  `LZD_ASSERT_NEXT(a_done_sticky, clk, rst, phase == PH_DONE, phase == PH_DONE)
  `LZD_ASSERT_IMPL(a_chunk_bound, clk, rst, seq == SQ_WR, nout <= LimitC)
endmodule

### rtl/core/lzo1x_stream_decompressor_core.sv
// channel | dir | tdata                       | tuser         | tlast
// s_axis  | in  | [7:0] in_byte                | [0] opcode    | -
// m_axis  | out | [7:0] out_byte               | [0] byte_valid,[2:1] status | last_of_run
// one item at a time; a literal byte is accepted in SQ_IDLE and parsed in SQ_PARSE,
// a byteless item then passes SQ_EMPTY; a match byte is read in SQ_RD, written back
// and presented in SQ_WAIT; SQ_WR goes on until the chunk is full or the match ends
// rst is synchronous, active high; the history window is not cleared
// a stalled output holds the sequencer; the next item is taken once the last result
// of the current one sits in the output register
module lzo1x_stream_decompressor_core
  import lzd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytesDefault,
  parameter int unsigned CHUNK_BYTES  = ChunkBytesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [0] byte_valid, [2:1] status
  output logic       m_axis_tlast    // last_of_run
);
  hist_req_t  hreq;
  logic [7:0] hrd;
  logic       bv;
  logic [1:0] st;

  // control and parser
  lzd_ctrl #(.WINDOW_BYTES(WINDOW_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tuser), .in_byte(s_axis_tdata),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_byte(m_axis_tdata), .out_bv(bv), .out_last(m_axis_tlast), .out_status(st),
    .hreq, .hrd
  );

  // history window
  lzd_history #(.WINDOW_BYTES(WINDOW_BYTES)) u_hist (
    .clk, .req(hreq), .rd_data(hrd)
  );

  assign m_axis_tuser = {st, bv};
endmodule
